>>> rtl/hlv_pkg.sv
// ----------------------------------------------------------------------------
// hlv_pkg
// Shared constants, codes, state encoding and the Q14 trig function of the
// Hough line accumulator.
// ----------------------------------------------------------------------------
package hlv_pkg;

   localparam int ANGLE_STEPS_DEF = 360;
   localparam int RHO_DEPTH_DEF   = 2048;
   localparam int MAX_PEAKS_DEF   = 16;

   localparam int VOTE_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [1:0] OP_VOTE  = 2'd0;
   localparam logic [1:0] OP_PEAKS = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_RHO_LIMIT       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_LOW         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_HIGH        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VOTE_THRESHOLD  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PEAK_SEPARATION = 3'd4;

   localparam logic [11:0] RHO_LIMIT_RST       = 12'd1448;
   localparam logic [10:0] ROW_LOW_RST         = 11'd2;
   localparam logic [10:0] ROW_HIGH_RST        = 11'd1000;
   localparam logic [15:0] VOTE_THRESHOLD_RST  = 16'd100;
   localparam logic [10:0] PEAK_SEPARATION_RST = 11'd20;

   typedef enum logic [12:0] {
      ST_INIT     = 13'b0_0000_0000_0001,
      ST_IDLE     = 13'b0_0000_0000_0010,
      ST_VOTE     = 13'b0_0000_0000_0100,
      ST_SCAN_RD  = 13'b0_0000_0000_1000,
      ST_SCAN_CHK = 13'b0_0000_0001_0000,
      ST_PK_RD    = 13'b0_0000_0010_0000,
      ST_PK_DIST  = 13'b0_0000_0100_0000,
      ST_PK_CMP   = 13'b0_0000_1000_0000,
      ST_PK_VOTE  = 13'b0_0001_0000_0000,
      ST_PK_DONE  = 13'b0_0010_0000_0000,
      ST_EMIT_RD  = 13'b0_0100_0000_0000,
      ST_EMIT_MEM = 13'b0_1000_0000_0000,
      ST_EMIT_OUT = 13'b1_0000_0000_0000
   } state_type;

   function automatic logic [63:0] term_div(input logic [63:0] v, input logic odd,
                                            input logic [3:0] n);
      logic [63:0] q;
      q = v;
      case ({odd, n})
         {1'b1, 4'd1}: q = v / 6;
         {1'b1, 4'd2}: q = v / 20;
         {1'b1, 4'd3}: q = v / 42;
         {1'b1, 4'd4}: q = v / 72;
         {1'b1, 4'd5}: q = v / 110;
         {1'b1, 4'd6}: q = v / 156;
         {1'b1, 4'd7}: q = v / 210;
         {1'b1, 4'd8}: q = v / 272;
         {1'b0, 4'd1}: q = v / 2;
         {1'b0, 4'd2}: q = v / 12;
         {1'b0, 4'd3}: q = v / 30;
         {1'b0, 4'd4}: q = v / 56;
         {1'b0, 4'd5}: q = v / 90;
         {1'b0, 4'd6}: q = v / 132;
         {1'b0, 4'd7}: q = v / 182;
         {1'b0, 4'd8}: q = v / 240;
         default:      q = v;
      endcase
      return q;
   endfunction

   // Taylor series in Q30, clamped to [0, 1] and rounded to Q14
   function automatic logic [15:0] series_q14(input logic [63:0] t, input logic odd);
      logic [63:0]        t2;
      logic [63:0]        term;
      logic signed [65:0] sum;
      logic [65:0]        v;
      t2   = (t * t) >> 30;
      term = odd ? t : 64'd1073741824;
      sum  = $signed({2'b00, term});
      for (int n = 1; n <= 8; n++) begin
         term = term_div((term * t2) >> 30, odd, 4'(n));
         if ((n % 2) == 1) begin
            sum = sum - $signed({2'b00, term});
         end else begin
            sum = sum + $signed({2'b00, term});
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > 66'sd1073741824) begin
         sum = 66'sd1073741824;
      end
      v = (unsigned'(sum) + 66'd32768) >> 16;
      return v[15:0];
   endfunction

   // returns {sin, cos}, each signed Q14
   function automatic logic [31:0] trig_q14(input logic [31:0] p);
      logic [63:0] t;
      logic [15:0] s;
      logic [15:0] c;
      logic [31:0] res;
      t   = (64'(p[29:0]) * 64'd1686629713) >> 30;
      s   = series_q14(t, 1'b1);
      c   = series_q14(t, 1'b0);
      res = {s, c};
      case (p[31:30])
         2'd0:    res = {s, c};
         2'd1:    res = {c, 16'(-c) ^ 16'(-c) ^ 16'(-s)};
         2'd2:    res = {16'(-s), 16'(-c)};
         default: res = {16'(-c), s};
      endcase
      return res;
   endfunction

endpackage

>>> rtl/hough_line_vote_and_peaks.sv
// ----------------------------------------------------------------------------
// hough_line_vote_and_peaks
// Hough line accumulator with peak picking, run by one small sequencer.
// ----------------------------------------------------------------------------
// A vote item steps through the angles, one angle step per cycle, through
// a five-stage read-modify-write pipeline on the accumulator's read and
// write ports. A peaks item reads the accumulator one cell at a time over
// rho_limit (capped at RHO_DEPTH) x ANGLE_STEPS cells; a cell above the
// threshold is compared against each listed peak, with a vote comparison for
// a near one; each result then waits on rsp_ready. A clear item, and reset,
// run a clearing pass over ANGLE_STEPS x RHO_DEPTH cells (737280 by default)
// during which req_ready stays low; configuration writes are still taken. A
// pending result does not block acceptance of the next item.
// ----------------------------------------------------------------------------
module hough_line_vote_and_peaks #(
   parameter int ANGLE_STEPS = hlv_pkg::ANGLE_STEPS_DEF,
   parameter int RHO_DEPTH   = hlv_pkg::RHO_DEPTH_DEF,
   parameter int MAX_PEAKS   = hlv_pkg::MAX_PEAKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [10:0] req_pixel_x,
   input  logic [10:0] req_pixel_y,
   input  logic [7:0]  req_edge_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [8:0]  rsp_peak_angle,
   output logic [10:0] rsp_peak_rho,
   output logic [15:0] rsp_peak_votes,
   output logic        rsp_peak_valid,
   output logic        rsp_peaks_dropped,
   output logic        rsp_last,
   input  logic                             csr_wr_en,
   input  logic [hlv_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hlv_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int A_W       = $clog2(ANGLE_STEPS);
   localparam int RHO_W     = $clog2(RHO_DEPTH);
   localparam int ACC_DEPTH = ANGLE_STEPS * RHO_DEPTH;
   localparam int ADDR_W    = $clog2(ACC_DEPTH);
   localparam int K_W       = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
   localparam int CNT_W     = $clog2(MAX_PEAKS + 1);
   localparam int V_W       = $clog2(ANGLE_STEPS + 5);
   localparam int D2_W      = (2 * RHO_W + 4 > 24) ? 2 * RHO_W + 4 : 24;
   localparam int VW        = hlv_pkg::VOTE_W;

   typedef struct packed {
      logic [A_W-1:0]    angle;
      logic [RHO_W-1:0]  rho;
      logic [ADDR_W-1:0] addr;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   hlv_pkg::state_type state_ff, state_in;

   logic [11:0] rho_limit_ff;
   logic [10:0] row_low_ff;
   logic [10:0] row_high_ff;
   logic [15:0] vote_threshold_ff;
   logic [10:0] peak_separation_ff;
   logic [21:0] sep2_ff;
   logic [11:0] lim;

   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [V_W-1:0]    vcnt_ff, vcnt_in;
   logic [10:0]       x_ff, x_in;
   logic [10:0]       y_ff, y_in;
   logic [ADDR_W-1:0] cell_addr_ff, cell_addr_in;
   logic [A_W-1:0]    a_cnt_ff, a_cnt_in;
   logic [RHO_W-1:0]  r_cnt_ff, r_cnt_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic              near_ff, near_in;
   logic [VW-1:0]     v_ff, v_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              dropped_ff, dropped_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [8:0]  rsp_angle_ff, rsp_angle_in;
   logic [10:0] rsp_rho_ff, rsp_rho_in;
   logic [15:0] rsp_votes_ff, rsp_votes_in;
   logic        rsp_pv_ff, rsp_pv_in;
   logic        rsp_drop_ff, rsp_drop_in;
   logic        rsp_last_ff, rsp_last_in;

   // vote pipeline
   logic                     issue;
   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic [A_W-1:0]           s1_angle_ff, s2_angle_ff, s3_angle_ff;
   logic signed [15:0]       rom_cos, rom_sin;
   logic signed [27:0]       prod_x_ff, prod_y_ff;
   logic signed [28:0]       sum;
   logic                     rho_ok;
   logic [RHO_W-1:0]         s3_rho_ff;
   logic [ADDR_W-1:0]        s4_addr_ff, s5_addr_ff;

   // peak distance
   logic signed [A_W:0]      da;
   logic signed [RHO_W:0]    dr;
   logic [2*A_W+1:0]         sq_a_ff;
   logic [2*RHO_W+1:0]       sq_r_ff;
   logic [D2_W-1:0]          d2;

   // memories
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [VW-1:0]     mem_wr_data;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [VW-1:0]     mem_rd_data;
   logic              list_wr_en;
   logic [K_W-1:0]    list_wr_idx;
   entry_type         cur_entry;
   entry_type         list_entry;
   logic [ENTRY_W-1:0] list_rd_data;

   logic cell_last;
   logic k_last;
   logic vote_ok;

   hlv_trig_rom #(
      .ANGLE_STEPS (ANGLE_STEPS),
      .A_W         (A_W)
   ) u_rom (
      .clock (clock),
      .idx   (vcnt_ff[A_W-1:0]),
      .cos_q (rom_cos),
      .sin_q (rom_sin)
   );

   hlv_accum_mem #(
      .DEPTH  (ACC_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_accum (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   hlv_peak_list #(
      .DEPTH   (MAX_PEAKS),
      .IDX_W   (K_W),
      .ENTRY_W (ENTRY_W)
   ) u_list (
      .clock   (clock),
      .wr_en   (list_wr_en),
      .wr_idx  (list_wr_idx),
      .wr_data (cur_entry),
      .rd_idx  (k_ff),
      .rd_data (list_rd_data)
   );

   assign list_entry = entry_type'(list_rd_data);
   assign cur_entry  = '{angle: a_cnt_ff, rho: r_cnt_ff, addr: cell_addr_ff};

   assign lim = (13'(rho_limit_ff) > 13'(RHO_DEPTH)) ? 12'(RHO_DEPTH) : rho_limit_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         rho_limit_ff       <= hlv_pkg::RHO_LIMIT_RST;
         row_low_ff         <= hlv_pkg::ROW_LOW_RST;
         row_high_ff        <= hlv_pkg::ROW_HIGH_RST;
         vote_threshold_ff  <= hlv_pkg::VOTE_THRESHOLD_RST;
         peak_separation_ff <= hlv_pkg::PEAK_SEPARATION_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            hlv_pkg::REG_RHO_LIMIT:       rho_limit_ff       <= csr_wdata[11:0];
            hlv_pkg::REG_ROW_LOW:         row_low_ff         <= csr_wdata[10:0];
            hlv_pkg::REG_ROW_HIGH:        row_high_ff        <= csr_wdata[10:0];
            hlv_pkg::REG_VOTE_THRESHOLD:  vote_threshold_ff  <= csr_wdata[15:0];
            hlv_pkg::REG_PEAK_SEPARATION: peak_separation_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      sep2_ff <= 22'(peak_separation_ff * peak_separation_ff);
   end

   // vote datapath
   assign issue  = (state_ff == hlv_pkg::ST_VOTE) && (vcnt_ff < V_W'(ANGLE_STEPS));
   assign sum    = 29'(prod_x_ff) + 29'(prod_y_ff);
   assign rho_ok = !sum[28] && (15'(sum[27:14]) < 15'(lim));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff && rho_ok;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_angle_ff <= vcnt_ff[A_W-1:0];
      s2_angle_ff <= s1_angle_ff;
      s3_angle_ff <= s2_angle_ff;
      prod_x_ff   <= 28'($signed({1'b0, x_ff}) * rom_cos);
      prod_y_ff   <= 28'($signed({1'b0, y_ff}) * rom_sin);
      s3_rho_ff   <= sum[14+RHO_W-1:14];
      s4_addr_ff  <= ADDR_W'(s3_rho_ff) * ADDR_W'(ANGLE_STEPS) + ADDR_W'(s3_angle_ff);
      s5_addr_ff  <= s4_addr_ff;
   end

   // peak distance datapath
   assign da = $signed({1'b0, list_entry.angle}) - $signed({1'b0, a_cnt_ff});
   assign dr = $signed({1'b0, list_entry.rho}) - $signed({1'b0, r_cnt_ff});
   assign d2 = D2_W'(sq_a_ff) + D2_W'(sq_r_ff);

   always_ff @(posedge clock) begin
      sq_a_ff <= (2*A_W+2)'(da * da);
      sq_r_ff <= (2*RHO_W+2)'(dr * dr);
   end

   assign cell_last = (a_cnt_ff == A_W'(ANGLE_STEPS - 1)) &&
                      (13'(r_cnt_ff) + 13'd1 == 13'(lim));
   assign k_last    = (CNT_W'(k_ff) + CNT_W'(1) == count_ff);
   assign vote_ok   = (req_edge_value != 8'd0) && (req_pixel_y > row_low_ff) &&
                      (req_pixel_y < row_high_ff);

   assign req_ready = (state_ff == hlv_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      vcnt_in      = vcnt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cell_addr_in = cell_addr_ff;
      a_cnt_in     = a_cnt_ff;
      r_cnt_in     = r_cnt_ff;
      k_in         = k_ff;
      near_in      = near_ff;
      v_in         = v_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_angle_in = rsp_angle_ff;
      rsp_rho_in   = rsp_rho_ff;
      rsp_votes_in = rsp_votes_ff;
      rsp_pv_in    = rsp_pv_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_last_in  = rsp_last_ff;
      mem_wr_en    = s5_valid_ff;
      mem_wr_addr  = s5_addr_ff;
      mem_wr_data  = (mem_rd_data == '1) ? mem_rd_data : mem_rd_data + VW'(1);
      mem_rd_addr  = s4_addr_ff;
      list_wr_en   = 1'b0;
      list_wr_idx  = k_ff;

      unique case (state_ff)
         hlv_pkg::ST_INIT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = '0;
            if (clr_addr_ff == ADDR_W'(ACC_DEPTH - 1)) begin
               clr_addr_in = '0;
               state_in    = hlv_pkg::ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + ADDR_W'(1);
            end
         end
         hlv_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_operation)
                  hlv_pkg::OP_VOTE: begin
                     if (vote_ok) begin
                        vcnt_in  = '0;
                        x_in     = req_pixel_x;
                        y_in     = req_pixel_y;
                        state_in = hlv_pkg::ST_VOTE;
                     end
                  end
                  hlv_pkg::OP_PEAKS: begin
                     cell_addr_in = '0;
                     a_cnt_in     = '0;
                     r_cnt_in     = '0;
                     k_in         = '0;
                     state_in     = (lim == 12'd0) ? hlv_pkg::ST_EMIT_RD : hlv_pkg::ST_SCAN_RD;
                  end
                  hlv_pkg::OP_CLEAR: begin
                     count_in    = '0;
                     dropped_in  = 1'b0;
                     clr_addr_in = '0;
                     state_in    = hlv_pkg::ST_INIT;
                  end
                  default: ;
               endcase
            end
         end
         hlv_pkg::ST_VOTE: begin
            vcnt_in = vcnt_ff + V_W'(1);
            if (vcnt_ff == V_W'(ANGLE_STEPS + 4)) begin
               state_in = hlv_pkg::ST_IDLE;
            end
         end
         hlv_pkg::ST_SCAN_RD: begin
            mem_rd_addr = cell_addr_ff;
            state_in    = hlv_pkg::ST_SCAN_CHK;
         end
         hlv_pkg::ST_SCAN_CHK: begin
            if (mem_rd_data > vote_threshold_ff) begin
               v_in     = mem_rd_data;
               k_in     = '0;
               near_in  = 1'b0;
               state_in = (count_ff == '0) ? hlv_pkg::ST_PK_DONE : hlv_pkg::ST_PK_RD;
            end else if (cell_last) begin
               k_in     = '0;
               state_in = hlv_pkg::ST_EMIT_RD;
            end else begin
               cell_addr_in = cell_addr_ff + ADDR_W'(1);
               a_cnt_in     = (a_cnt_ff == A_W'(ANGLE_STEPS - 1)) ? '0 : a_cnt_ff + A_W'(1);
               r_cnt_in     = (a_cnt_ff == A_W'(ANGLE_STEPS - 1)) ? r_cnt_ff + RHO_W'(1)
                                                                   : r_cnt_ff;
               state_in     = hlv_pkg::ST_SCAN_RD;
            end
         end
         hlv_pkg::ST_PK_RD: begin
            state_in = hlv_pkg::ST_PK_DIST;
         end
         hlv_pkg::ST_PK_DIST: begin
            state_in = hlv_pkg::ST_PK_CMP;
         end
         hlv_pkg::ST_PK_CMP: begin
            if (d2 < D2_W'(sep2_ff)) begin
               near_in     = 1'b1;
               mem_rd_addr = list_entry.addr;
               state_in    = hlv_pkg::ST_PK_VOTE;
            end else if (k_last) begin
               state_in = hlv_pkg::ST_PK_DONE;
            end else begin
               k_in     = k_ff + K_W'(1);
               state_in = hlv_pkg::ST_PK_RD;
            end
         end
         hlv_pkg::ST_PK_VOTE: begin
            if (v_ff > mem_rd_data) begin
               list_wr_en = 1'b1;
            end
            if (k_last) begin
               state_in = hlv_pkg::ST_PK_DONE;
            end else begin
               k_in     = k_ff + K_W'(1);
               state_in = hlv_pkg::ST_PK_RD;
            end
         end
         hlv_pkg::ST_PK_DONE: begin
            if (!near_ff) begin
               if (count_ff < CNT_W'(MAX_PEAKS)) begin
                  list_wr_en  = 1'b1;
                  list_wr_idx = count_ff[K_W-1:0];
                  count_in    = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
            if (cell_last) begin
               k_in     = '0;
               state_in = hlv_pkg::ST_EMIT_RD;
            end else begin
               cell_addr_in = cell_addr_ff + ADDR_W'(1);
               a_cnt_in     = (a_cnt_ff == A_W'(ANGLE_STEPS - 1)) ? '0 : a_cnt_ff + A_W'(1);
               r_cnt_in     = (a_cnt_ff == A_W'(ANGLE_STEPS - 1)) ? r_cnt_ff + RHO_W'(1)
                                                                   : r_cnt_ff;
               state_in     = hlv_pkg::ST_SCAN_RD;
            end
         end
         hlv_pkg::ST_EMIT_RD: begin
            state_in = (count_ff == '0) ? hlv_pkg::ST_EMIT_OUT : hlv_pkg::ST_EMIT_MEM;
         end
         hlv_pkg::ST_EMIT_MEM: begin
            mem_rd_addr = list_entry.addr;
            state_in    = hlv_pkg::ST_EMIT_OUT;
         end
         hlv_pkg::ST_EMIT_OUT: begin
            mem_rd_addr = list_entry.addr;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_drop_in  = dropped_ff;
               if (count_ff == '0) begin
                  rsp_angle_in = '0;
                  rsp_rho_in   = '0;
                  rsp_votes_in = '0;
                  rsp_pv_in    = 1'b0;
                  rsp_last_in  = 1'b1;
                  state_in     = hlv_pkg::ST_IDLE;
               end else begin
                  rsp_angle_in = 9'(list_entry.angle);
                  rsp_rho_in   = 11'(list_entry.rho);
                  rsp_votes_in = mem_rd_data;
                  rsp_pv_in    = 1'b1;
                  rsp_last_in  = k_last;
                  if (k_last) begin
                     state_in = hlv_pkg::ST_IDLE;
                  end else begin
                     k_in     = k_ff + K_W'(1);
                     state_in = hlv_pkg::ST_EMIT_RD;
                  end
               end
            end
         end
         default: state_in = hlv_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hlv_pkg::ST_INIT;
         clr_addr_ff  <= '0;
         vcnt_ff      <= '0;
         cell_addr_ff <= '0;
         a_cnt_ff     <= '0;
         r_cnt_ff     <= '0;
         k_ff         <= '0;
         near_ff      <= 1'b0;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         vcnt_ff      <= vcnt_in;
         cell_addr_ff <= cell_addr_in;
         a_cnt_ff     <= a_cnt_in;
         r_cnt_ff     <= r_cnt_in;
         k_ff         <= k_in;
         near_ff      <= near_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      v_ff         <= v_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_rho_ff   <= rsp_rho_in;
      rsp_votes_ff <= rsp_votes_in;
      rsp_pv_ff    <= rsp_pv_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_peak_angle    = rsp_angle_ff;
   assign rsp_peak_rho      = rsp_rho_ff;
   assign rsp_peak_votes    = rsp_votes_ff;
   assign rsp_peak_valid    = rsp_pv_ff;
   assign rsp_peaks_dropped = rsp_drop_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

>>> rtl/hlv_trig_rom.sv
// ----------------------------------------------------------------------------
// hlv_trig_rom
// Constant cosine/sine table in Q14, one entry per angle step, registered read.
// ----------------------------------------------------------------------------
module hlv_trig_rom #(
   parameter int ANGLE_STEPS = hlv_pkg::ANGLE_STEPS_DEF,
   parameter int A_W         = $clog2(hlv_pkg::ANGLE_STEPS_DEF)
) (
   input  logic               clock,
   input  logic [A_W-1:0]     idx,
   output logic signed [15:0] cos_q,
   output logic signed [15:0] sin_q
);

   logic [31:0] tab [ANGLE_STEPS];

   for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_tab
      localparam logic [31:0] P = 32'((64'(g) << 32) / ANGLE_STEPS);
      assign tab[g] = hlv_pkg::trig_q14(P);
   end

   always_ff @(posedge clock) begin
      {sin_q, cos_q} <= tab[idx];
   end

endmodule

>>> rtl/hlv_accum_mem.sv
// ----------------------------------------------------------------------------
// hlv_accum_mem
// Vote accumulator storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hlv_accum_mem #(
   parameter int DEPTH  = hlv_pkg::ANGLE_STEPS_DEF * hlv_pkg::RHO_DEPTH_DEF,
   parameter int ADDR_W = $clog2(hlv_pkg::ANGLE_STEPS_DEF * hlv_pkg::RHO_DEPTH_DEF)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [hlv_pkg::VOTE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [hlv_pkg::VOTE_W-1:0] rd_data
);

   logic [hlv_pkg::VOTE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/hlv_peak_list.sv
// ----------------------------------------------------------------------------
// hlv_peak_list
// Peak list storage: angle, distance and cell address of each listed peak.
// ----------------------------------------------------------------------------
module hlv_peak_list #(
   parameter int DEPTH   = hlv_pkg::MAX_PEAKS_DEF,
   parameter int IDX_W   = $clog2(hlv_pkg::MAX_PEAKS_DEF),
   parameter int ENTRY_W = 41
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_idx,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic [IDX_W-1:0]   rd_idx,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data <= mem[rd_idx];
   end

endmodule

>>> rtl/hlv_checker.sv
// ----------------------------------------------------------------------------
// hlv_checker
// Port-level checks on the result channel of the Hough line accumulator.
// ----------------------------------------------------------------------------
module hlv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [8:0]  rsp_peak_angle,
   input logic [10:0] rsp_peak_rho,
   input logic [15:0] rsp_peak_votes,
   input logic        rsp_peak_valid,
   input logic        rsp_peaks_dropped,
   input logic        rsp_last
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_peak_angle) &&
      $stable(rsp_peak_rho) && $stable(rsp_peak_votes) && $stable(rsp_last) &&
      $stable(rsp_peak_valid) && $stable(rsp_peaks_dropped))
      else $error("result item changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_peak_valid |-> rsp_last)
      else $error("empty-list item not marked last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_peak_valid |-> rsp_peak_angle == 9'd0 && rsp_peak_rho == 11'd0 &&
      rsp_peak_votes == 16'd0)
      else $error("empty-list item carries peak data");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind hough_line_vote_and_peaks hlv_checker u_hlv_checker (.*);
